>>> hdl/spectrum_smooth_ballistics_top_assert.svh
`ifndef SPECTRUM_SMOOTH_BALLISTICS_TOP_ASSERT_SVH
`define SPECTRUM_SMOOTH_BALLISTICS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SSB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssb assertion failed");
`define SSB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssb assertion failed");
`else
`define SSB_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/ssb_pkg.sv
package ssb_pkg;

  localparam int MAX_BINS_DEF    = 4096;
  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int BIN_COUNT_W     = 13;
  localparam int ALPHA_W         = 17;
  localparam int ALPHA_FRAC      = 16;
  localparam int ALPHA_ONE       = 65536;
  localparam int ALPHA_HALF      = 32768;
  localparam int FLOOR_DB        = -25600;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 13'd512;

  localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENV_ENABLE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_ALPHA = 2'd2;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_HALF,
    KIND_THIRD
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  last;
  } op_ctl_t;

endpackage

>>> hdl/ssb_front.sv
module ssb_front #(
  parameter int MAX_BINS    = ssb_pkg::MAX_BINS_DEF,
  parameter int LEVEL_WIDTH = ssb_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic [$clog2(MAX_BINS)-1:0]    last_idx,
  input  logic                           clearing,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [LEVEL_WIDTH-1:0]  level_db,
  input  logic                           op_take,
  output ssb_pkg::op_ctl_t               op_ctl,
  output logic [$clog2(MAX_BINS)-1:0]    op_idx,
  output logic signed [LEVEL_WIDTH+1:0]  op_sum
);
  import ssb_pkg::*;

  localparam int IdxW = $clog2(MAX_BINS);
  localparam int SumW = LEVEL_WIDTH + 2;

  logic signed [LEVEL_WIDTH-1:0] prev_level;
  logic signed [LEVEL_WIDTH-1:0] prev_prev_level;
  logic [IdxW-1:0]               bin_counter;
  logic [IdxW-1:0]               bin_counter_next;

  op_ctl_t                a_ctl, b_ctl;
  logic [IdxW-1:0]        a_idx, b_idx;
  logic signed [SumW-1:0] a_sum, b_sum;

  op_ctl_t                a_ctl_next, b_ctl_next;
  logic [IdxW-1:0]        a_idx_next, b_idx_next;
  logic signed [SumW-1:0] a_sum_next, b_sum_next;

  logic signed [SumW-1:0] lvl_x, prev_x, pp_x, sum2, sum3;
  logic                   accept;
  logic                   issue;

  assign issue    = a_ctl.valid && op_take;
  assign in_stall = clearing || b_ctl.valid || (a_ctl.valid && !op_take);
  assign accept   = in_valid && !in_stall;

  assign op_ctl = a_ctl;
  assign op_idx = a_idx;
  assign op_sum = a_sum;

  always_comb begin
    lvl_x  = SumW'(level_db);
    prev_x = SumW'(prev_level);
    pp_x   = SumW'(prev_prev_level);
    sum2   = prev_x + lvl_x;
    sum3   = pp_x + prev_x + lvl_x;

    a_ctl_next       = '{1'b0, KIND_PASS, 1'b0};
    b_ctl_next       = '{1'b0, KIND_PASS, 1'b0};
    a_idx_next       = bin_counter - IdxW'(1);
    b_idx_next       = bin_counter;
    a_sum_next       = sum3;
    b_sum_next       = sum2;
    bin_counter_next = bin_counter + IdxW'(1);

    if (bin_counter == '0) begin
      a_idx_next = '0;
      a_sum_next = lvl_x;
      if (last_idx == '0) begin
        a_ctl_next       = '{1'b1, KIND_PASS, 1'b1};
        bin_counter_next = '0;
      end
    end else begin
      a_ctl_next.valid = 1'b1;
      if (bin_counter == IdxW'(1)) begin
        a_ctl_next.kind = KIND_HALF;
        a_sum_next      = sum2;
      end else begin
        a_ctl_next.kind = KIND_THIRD;
      end
      if (bin_counter == last_idx) begin
        b_ctl_next       = '{1'b1, KIND_HALF, 1'b1};
        bin_counter_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      a_ctl           <= '0;
      b_ctl           <= '0;
      bin_counter     <= '0;
      prev_level      <= '0;
      prev_prev_level <= '0;
    end else if (accept) begin
      a_ctl           <= a_ctl_next;
      a_idx           <= a_idx_next;
      a_sum           <= a_sum_next;
      b_ctl           <= b_ctl_next;
      b_idx           <= b_idx_next;
      b_sum           <= b_sum_next;
      bin_counter     <= bin_counter_next;
      prev_prev_level <= prev_level;
      prev_level      <= level_db;
    end else if (issue) begin
      a_ctl       <= b_ctl;
      a_idx       <= b_idx;
      a_sum       <= b_sum;
      b_ctl.valid <= 1'b0;
    end
  end

endmodule

>>> hdl/ssb_smooth.sv
module ssb_smooth #(
  parameter int MAX_BINS    = ssb_pkg::MAX_BINS_DEF,
  parameter int LEVEL_WIDTH = ssb_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ssb_pkg::op_ctl_t               op_ctl,
  input  logic [$clog2(MAX_BINS)-1:0]    op_idx,
  input  logic signed [LEVEL_WIDTH+1:0]  op_sum,
  output logic                           op_take,
  output ssb_pkg::op_ctl_t               sm_ctl,
  output logic [$clog2(MAX_BINS)-1:0]    sm_idx,
  output logic signed [LEVEL_WIDTH-1:0]  sm_val,
  input  logic                           sm_take
);
  import ssb_pkg::*;

  localparam int IdxW  = $clog2(MAX_BINS);
  localparam int SumW  = LEVEL_WIDTH + 2;
  localparam int MagW  = LEVEL_WIDTH + 1;
  localparam int ProdW = 2 * MagW;
  localparam logic [MagW-1:0] Recip3 = MagW'(((64'd1 << (MagW + 1)) + 64'd2) / 64'd3);

  op_ctl_t                p1_ctl;
  logic [IdxW-1:0]        p1_idx;
  logic signed [SumW-1:0] p1_sum;

  op_ctl_t                       p2_ctl;
  logic [IdxW-1:0]               p2_idx;
  logic signed [LEVEL_WIDTH-1:0] p2_lvl;
  logic                          p2_neg;
  logic [MagW-1:0]               p2_magp1;
  logic [ProdW-1:0]              p2_prod;

  logic             p1_neg;
  logic [SumW-1:0]  p1_mag;
  logic [MagW-1:0]  p1_magp1;
  logic [ProdW-1:0] p1_prod;
  logic             move12;

  logic [MagW-1:0] q_mag;
  logic [MagW-1:0] q_val;

  assign move12  = p1_ctl.valid && (!p2_ctl.valid || sm_take);
  assign op_take = !p1_ctl.valid || move12;

  always_comb begin
    p1_neg   = p1_sum[SumW-1];
    p1_mag   = p1_neg ? (~p1_sum + SumW'(1)) : p1_sum;
    p1_magp1 = MagW'(p1_mag) + MagW'(1);
    p1_prod  = ProdW'(p1_magp1) * ProdW'(Recip3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_ctl <= '0;
    end else if (op_ctl.valid && op_take) begin
      p1_ctl <= op_ctl;
    end else if (move12) begin
      p1_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ctl.valid && op_take) begin
      p1_idx <= op_idx;
      p1_sum <= op_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_ctl <= '0;
    end else if (move12) begin
      p2_ctl <= p1_ctl;
    end else if (p2_ctl.valid && sm_take) begin
      p2_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move12) begin
      p2_idx   <= p1_idx;
      p2_lvl   <= LEVEL_WIDTH'(p1_sum);
      p2_neg   <= p1_neg;
      p2_magp1 <= p1_magp1;
      p2_prod  <= p1_prod;
    end
  end

  always_comb begin
    q_mag = p2_magp1 >> 1;
    unique case (p2_ctl.kind)
      KIND_THIRD: q_mag = MagW'(p2_prod >> (MagW + 1));
      KIND_HALF:  q_mag = p2_magp1 >> 1;
      KIND_PASS:  q_mag = p2_magp1 >> 1;
      default:    q_mag = p2_magp1 >> 1;
    endcase
    q_val = p2_neg ? (~q_mag + MagW'(1)) : q_mag;
    if (p2_ctl.kind == KIND_PASS) begin
      sm_val = p2_lvl;
    end else begin
      sm_val = LEVEL_WIDTH'(q_val);
    end
  end

  assign sm_ctl = p2_ctl;
  assign sm_idx = p2_idx;

endmodule

>>> hdl/ssb_env.sv
`include "spectrum_smooth_ballistics_top_assert.svh"

module ssb_env #(
  parameter int MAX_BINS    = ssb_pkg::MAX_BINS_DEF,
  parameter int LEVEL_WIDTH = ssb_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic                           envelope_enable,
  input  logic [ssb_pkg::ALPHA_W-1:0]    release_alpha,
  output logic                           clearing,
  input  ssb_pkg::op_ctl_t               sm_ctl,
  input  logic [$clog2(MAX_BINS)-1:0]    sm_idx,
  input  logic signed [LEVEL_WIDTH-1:0]  sm_val,
  output logic                           sm_take,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(MAX_BINS)-1:0]    bin_index,
  output logic signed [LEVEL_WIDTH-1:0]  display_db,
  output logic                           frame_end
);
  import ssb_pkg::*;

  localparam int IdxW  = $clog2(MAX_BINS);
  localparam int DiffW = LEVEL_WIDTH + 1;
  localparam int ProdW = DiffW + ALPHA_W + 1;

  logic [LEVEL_WIDTH-1:0] env_mem [MAX_BINS];
  logic [LEVEL_WIDTH-1:0] rd_q;
  logic                   rd_en;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  logic [LEVEL_WIDTH-1:0] wr_data;

  logic [IdxW-1:0] clr_addr;

  logic                          v3, last3;
  logic [IdxW-1:0]               idx3;
  logic signed [LEVEL_WIDTH-1:0] sm3;

  logic                          v4, last4, attack4;
  logic [IdxW-1:0]               idx4;
  logic signed [LEVEL_WIDTH-1:0] sm4, old4;
  logic signed [ProdW-1:0]       prod4;

  logic signed [LEVEL_WIDTH-1:0] old3;
  logic signed [DiffW-1:0]       diff3;
  logic signed [ALPHA_W:0]       alpha_s;
  logic signed [ProdW-1:0]       prod3;

  logic                          neg4;
  logic [ProdW-1:0]              pmag4;
  logic [ProdW-1:0]              rnd4;
  logic signed [ProdW-1:0]       delta4;
  logic signed [ProdW-1:0]       rel4;
  logic signed [LEVEL_WIDTH-1:0] shown4;

  logic hazard, ready4, move4, move34, free3;

  assign hazard  = (v3 && (idx3 == sm_idx)) || (v4 && (idx4 == sm_idx));
  assign ready4  = !out_valid || !out_stall;
  assign move4   = v4 && ready4;
  assign move34  = v3 && (!v4 || ready4);
  assign free3   = !v3 || move34;
  assign sm_take = free3 && !hazard && !clearing;
  assign rd_en   = sm_ctl.valid && sm_take;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == IdxW'(MAX_BINS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + IdxW'(1);
    end
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = LEVEL_WIDTH'(FLOOR_DB);
    end else begin
      wr_en   = move4 && envelope_enable;
      wr_addr = idx4;
      wr_data = shown4;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      env_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= env_mem[sm_idx];
    end
  end

  always_comb begin
    old3    = rd_q;
    diff3   = DiffW'(sm3) - DiffW'(old3);
    alpha_s = {1'b0, release_alpha};
    prod3   = ProdW'(diff3) * ProdW'(alpha_s);
  end

  always_comb begin
    neg4   = prod4[ProdW-1];
    pmag4  = neg4 ? (~prod4 + ProdW'(1)) : prod4;
    rnd4   = (pmag4 + ProdW'(ALPHA_HALF)) >> ALPHA_FRAC;
    delta4 = neg4 ? (~rnd4 + ProdW'(1)) : rnd4;
    rel4   = ProdW'(old4) + delta4;
    if (!envelope_enable || attack4) begin
      shown4 = sm4;
    end else begin
      shown4 = LEVEL_WIDTH'(rel4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        v3 <= 1'b1;
      end else if (move34) begin
        v3 <= 1'b0;
      end
      if (move34) begin
        v4 <= 1'b1;
      end else if (move4) begin
        v4 <= 1'b0;
      end
      if (move4) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx3  <= sm_idx;
      last3 <= sm_ctl.last;
      sm3   <= sm_val;
    end
    if (move34) begin
      idx4    <= idx3;
      last4   <= last3;
      sm4     <= sm3;
      old4    <= old3;
      attack4 <= !diff3[DiffW-1];
      prod4   <= prod3;
    end
    if (move4) begin
      bin_index  <= idx4;
      display_db <= shown4;
      frame_end  <= last4;
    end
  end

  `SSB_ASSERT_IMP(a_rmw_idx_differ, clk, rst, v3 && v4, idx3 != idx4)
  `SSB_ASSERT_NXT(a_restart_clears, clk, rst, restart, clearing)
  `SSB_ASSERT_IMP(a_out_from_p4, clk, rst, $rose(out_valid), $past(v4))

endmodule

>>> hdl/spectrum_smooth_ballistics_top.sv
// Channel   Handshake             Payload
// input     in_valid / in_stall   level_db
// output    out_valid / out_stall bin_index, display_db, frame_end
// config    cfg_write             cfg_index, cfg_data
//
// One bin per cycle while nothing stalls; in a frame of two or more bins the last bin gives two
// results and holds in_stall until the second issues. In a one-bin frame each bin waits for
// the envelope read-modify-write on entry 0. A result passes the front queue, the divide
// stages, the envelope memory and the output register. After reset and after each bin_count
// write the envelope memory is swept to the floor, all MAX_BINS entries, with in_stall high.
// out_stall holds the output register and backs up the pipeline to in_stall.
module spectrum_smooth_ballistics_top #(
  parameter int MAX_BINS    = ssb_pkg::MAX_BINS_DEF,
  parameter int LEVEL_WIDTH = ssb_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [LEVEL_WIDTH-1:0]     level_db,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [$clog2(MAX_BINS)-1:0]       bin_index,
  output logic signed [LEVEL_WIDTH-1:0]     display_db,
  output logic                              frame_end,
  input  logic                              cfg_write,
  input  logic [ssb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ssb_pkg::ALPHA_W-1:0]       cfg_data
);
  import ssb_pkg::*;

  localparam int IdxW = $clog2(MAX_BINS);

  logic [BIN_COUNT_W-1:0] bin_count;
  logic                   envelope_enable;
  logic [ALPHA_W-1:0]     release_alpha;
  logic                   restart;
  logic [31:0]            count_ext;
  logic [IdxW-1:0]        last_idx;
  logic                   clearing;

  op_ctl_t                       op_ctl;
  logic [IdxW-1:0]               op_idx;
  logic signed [LEVEL_WIDTH+1:0] op_sum;
  logic                          op_take;

  op_ctl_t                       sm_ctl;
  logic [IdxW-1:0]               sm_idx;
  logic signed [LEVEL_WIDTH-1:0] sm_val;
  logic                          sm_take;

  assign restart = cfg_write && (cfg_index == REG_BIN_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count       <= BIN_COUNT_RESET;
      envelope_enable <= 1'b0;
      release_alpha   <= ALPHA_W'(ALPHA_ONE);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BIN_COUNT:     bin_count <= cfg_data[BIN_COUNT_W-1:0];
        REG_ENV_ENABLE:    envelope_enable <= cfg_data[0];
        REG_RELEASE_ALPHA: begin
          release_alpha <= (cfg_data > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_ext = 32'(bin_count);
    if (count_ext == 32'd0) begin
      last_idx = '0;
    end else if (count_ext > 32'(MAX_BINS)) begin
      last_idx = IdxW'(MAX_BINS - 1);
    end else begin
      last_idx = IdxW'(count_ext - 32'd1);
    end
  end

  ssb_front #(
    .MAX_BINS    (MAX_BINS),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .last_idx (last_idx),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .level_db (level_db),
    .op_take  (op_take),
    .op_ctl   (op_ctl),
    .op_idx   (op_idx),
    .op_sum   (op_sum)
  );

  ssb_smooth #(
    .MAX_BINS    (MAX_BINS),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_smooth (
    .clk     (clk),
    .rst     (rst),
    .op_ctl  (op_ctl),
    .op_idx  (op_idx),
    .op_sum  (op_sum),
    .op_take (op_take),
    .sm_ctl  (sm_ctl),
    .sm_idx  (sm_idx),
    .sm_val  (sm_val),
    .sm_take (sm_take)
  );

  ssb_env #(
    .MAX_BINS    (MAX_BINS),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_env (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .envelope_enable (envelope_enable),
    .release_alpha   (release_alpha),
    .clearing        (clearing),
    .sm_ctl          (sm_ctl),
    .sm_idx          (sm_idx),
    .sm_val          (sm_val),
    .sm_take         (sm_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .bin_index       (bin_index),
    .display_db      (display_db),
    .frame_end       (frame_end)
  );

endmodule

>>> bench/spectrum_smooth_ballistics_top_test.sv
module spectrum_smooth_ballistics_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssb_pkg::*;

  localparam int BIN_W = $clog2(MAX_BINS_DEF);
  localparam int LVL_W = LEVEL_WIDTH_DEF;
  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int BIG_PHASE = 8;
  localparam int BIG_PARTIAL = 400;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [BIN_W-1:0]        bin;
    logic signed [LVL_W-1:0] db;
    logic                    last;
  } disp_t;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_LEVEL,
    STEP_KNOWN
  } step_t;

  typedef struct packed {
    step_t                   kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [ALPHA_W-1:0]      data;
    logic signed [LVL_W-1:0] lvl;
    logic signed [LVL_W-1:0] known;
  } script_row_t;

  localparam int SCRIPT_LEN = 35;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [LVL_W-1:0] level_db;
  logic                    out_valid;
  logic                    out_stall;
  logic [BIN_W-1:0]        bin_index;
  logic signed [LVL_W-1:0] display_db;
  logic                    frame_end;
  logic                    cfg_write;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [ALPHA_W-1:0]      cfg_data;

  spectrum_smooth_ballistics_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .level_db   (level_db),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bin_index  (bin_index),
    .display_db (display_db),
    .frame_end  (frame_end),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // smoother and envelope state
  int cfg_bins;
  bit env_on;
  int alpha_q;
  int last_lvl;
  int last2_lvl;
  int next_bin;
  int env_level [MAX_BINS_DEF];

  disp_t display_due [$];
  int    mismatch_count;
  int    cycles;
  int    fed;
  bit    calm;
  int    hold_left;
  int    run_left;

  script_row_t script [SCRIPT_LEN] = '{
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd32767,  16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd32767,  16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd32768, 16'sd0},
    '{STEP_WRITE, REG_BIN_COUNT,     17'd0,      16'sd0,      16'sd0},
    '{STEP_KNOWN, REG_BIN_COUNT,     17'd0,      -16'sd32768, -16'sd32768},
    '{STEP_KNOWN, REG_BIN_COUNT,     17'd0,      16'sd32767,  16'sd32767},
    '{STEP_KNOWN, REG_BIN_COUNT,     17'd0,      -16'sd25600, -16'sd25600},
    '{STEP_KNOWN, REG_BIN_COUNT,     17'd0,      -16'sd30000, -16'sd30000},
    '{STEP_KNOWN, REG_BIN_COUNT,     17'd0,      16'sd0,      16'sd0},
    '{STEP_KNOWN, REG_BIN_COUNT,     17'd0,      -16'sd1,     -16'sd1},
    '{STEP_WRITE, REG_ENV_ENABLE,    17'd1,      16'sd0,      16'sd0},
    '{STEP_WRITE, REG_RELEASE_ALPHA, 17'h1FFFF,  16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd1000,   16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd32768, 16'sd0},
    '{STEP_WRITE, REG_RELEASE_ALPHA, 17'd0,      16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd5000,   16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd32768, 16'sd0},
    '{STEP_WRITE, REG_RELEASE_ALPHA, 17'd32768,  16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd32767,  16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd32768, 16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd32768, 16'sd0},
    '{STEP_WRITE, REG_BIN_COUNT,     17'd8191,   16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd100,    16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd100,   16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd77,     16'sd0},
    '{STEP_WRITE, REG_ENV_ENABLE,    17'd0,      16'sd0,      16'sd0},
    '{STEP_WRITE, REG_BIN_COUNT,     17'd2,      16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd1,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd2,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd1,     16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd2,     16'sd0},
    '{STEP_WRITE, REG_BIN_COUNT,     17'd3,      16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      -16'sd1,     16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd0,      16'sd0},
    '{STEP_LEVEL, REG_BIN_COUNT,     17'd0,      16'sd0,      16'sd0}
  };

  function automatic longint round_div(input longint s, input longint d);
    if (s >= 0) begin
      return (s + d / 2) / d;
    end
    return -((-s + d / 2) / d);
  endfunction

  function automatic int eff_bins();
    if (cfg_bins == 0) begin
      return 1;
    end
    if (cfg_bins > MAX_BINS_DEF) begin
      return MAX_BINS_DEF;
    end
    return cfg_bins;
  endfunction

  function automatic void restart_frame();
    for (int k = 0; k < MAX_BINS_DEF; k++) begin
      env_level[k] = FLOOR_DB;
    end
    last_lvl = 0;
    last2_lvl = 0;
    next_bin = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [ALPHA_W-1:0] val);
    case (idx)
      REG_BIN_COUNT: begin
        cfg_bins = int'(val[BIN_COUNT_W-1:0]);
        restart_frame();
      end
      REG_ENV_ENABLE: begin
        env_on = val[0];
      end
      REG_RELEASE_ALPHA: begin
        alpha_q = int'(val);
      end
      default: begin
      end
    endcase
  endfunction

  // instant attack, release by alpha toward the fresh value
  function automatic disp_t shade_bin(input int idx, input int smooth, input bit last);
    disp_t r;
    int    held;
    int    a;
    int    shown;
    shown = smooth;
    if (env_on) begin
      held = env_level[idx];
      a = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
      if (smooth < held) begin
        shown = held + int'(round_div(longint'(smooth - held) * a, ALPHA_ONE));
      end
      env_level[idx] = shown;
    end
    r.bin = idx[BIN_W-1:0];
    r.db = shown[LVL_W-1:0];
    r.last = last;
    return r;
  endfunction

  function automatic int step_bins(input logic signed [LVL_W-1:0] lvl,
                                   output disp_t r0, output disp_t r1);
    int lv;
    int n;
    int i;
    int cnt;
    lv = lvl;
    n = eff_bins();
    i = next_bin;
    cnt = 0;
    r0 = '0;
    r1 = '0;
    if (i >= n) begin
      i = 0;
    end
    if (i == 0) begin
      if (n == 1) begin
        r0 = shade_bin(0, lv, 1'b1);
        cnt = 1;
        next_bin = 0;
      end else begin
        next_bin = 1;
      end
    end else begin
      if (i == 1) begin
        r0 = shade_bin(0, int'(round_div(last_lvl + lv, 2)), 1'b0);
      end else begin
        r0 = shade_bin(i - 1, int'(round_div(last2_lvl + last_lvl + lv, 3)), 1'b0);
      end
      cnt = 1;
      if (i == n - 1) begin
        r1 = shade_bin(i, int'(round_div(last_lvl + lv, 2)), 1'b1);
        cnt = 2;
        next_bin = 0;
      end else begin
        next_bin = i + 1;
      end
    end
    last2_lvl = last_lvl;
    last_lvl = lv;
    return cnt;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 15);
    if (r < 9) begin
      return 0;
    end else if (r < 14) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [LVL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      case ($urandom_range(0, 2))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        default: return -16'sd25600;
      endcase
    end else if (r < 4) begin
      return 16'($urandom);
    end
    return 16'(FLOOR_DB + int'($urandom_range(0, 30000)));
  endfunction

  function automatic int pick_bins();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) begin
      return r;
    end else if (r == 4) begin
      return $urandom_range(41, 200);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic feed_level(input logic signed [LVL_W-1:0] lvl, input bit has_known,
                            input logic signed [LVL_W-1:0] known);
    disp_t r0;
    disp_t r1;
    int    cnt;
    @(negedge clk);
    in_valid <= 1'b1;
    level_db <= lvl;
    do @(posedge clk); while (in_stall);
    cnt = step_bins(lvl, r0, r1);
    if (has_known) begin
      r0 = '{bin: '0, db: known, last: 1'b1};
    end
    if (cnt > 0) begin
      display_due = {display_due, r0};
    end
    if (cnt > 1) begin
      display_due = {display_due, r1};
    end
    fed++;
  endtask

  task automatic rest_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      level_db <= 16'($urandom);
    end
  endtask

  // drop valid, drain outstanding results and let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (display_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [CFG_INDEX_W-1:0] idx, input logic [ALPHA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** spectrum_smooth_ballistics_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
      hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_display
    disp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (display_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transaction: bin %0d db %0d end %0d",
                   bin_index, display_db, frame_end);
        end
      end else begin
        want = display_due.pop_front();
        if (bin_index !== want.bin || display_db !== want.db || frame_end !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: bin %0d db %0d end %0d, expected bin %0d db %0d end %0d",
                     bin_index, display_db, frame_end, want.bin, want.db, want.last);
          end
        end
      end
    end
  end

  initial begin : run
    int  phase;
    int  n_bins;
    int  frames;
    int  part_len;
    bit  partial_open;
    bit  prev_write;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    level_db = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_BIN_COUNT;
    cfg_data = '0;
    hold_left = 0;
    run_left = 0;
    mismatch_count = 0;
    cycles = 0;
    fed = 0;
    calm = 1'b0;
    cfg_bins = int'(BIN_COUNT_RESET);
    env_on = 1'b0;
    alpha_q = ALPHA_ONE;
    restart_frame();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    prev_write = 1'b0;
    for (int k = 0; k < SCRIPT_LEN; k++) begin
      if (script[k].kind == STEP_WRITE) begin
        if (!prev_write) begin
          settle();
        end
        cfg_set(script[k].idx, script[k].data);
        prev_write = 1'b1;
      end else begin
        feed_level(script[k].lvl, script[k].kind == STEP_KNOWN, script[k].known);
        rest_input(pick_gap());
        prev_write = 1'b0;
      end
    end

    phase = 0;
    partial_open = 1'b0;
    fed = 0;
    while (fed < RANDOM_ITEMS || phase <= BIG_PHASE) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      cfg_set(REG_ENV_ENABLE, 17'($urandom_range(0, 3) != 0));
      cfg_set(REG_RELEASE_ALPHA, pick_alpha());
      if (phase == BIG_PHASE) begin
        cfg_set(REG_BIN_COUNT, ($urandom_range(0, 1) != 0) ? 17'd4096 : 17'd8191);
      end else if (partial_open || phase == BIG_PHASE + 1 || $urandom_range(0, 2) == 0) begin
        cfg_set(REG_BIN_COUNT, 17'(pick_bins()));
      end
      n_bins = eff_bins();
      frames = (phase == BIG_PHASE) ? 0 : $urandom_range(1, 4);
      repeat (frames) begin
        repeat (n_bins) begin
          feed_level(pick_level(), 1'b0, '0);
          rest_input(pick_gap());
        end
      end
      partial_open = 1'b0;
      if (phase == BIG_PHASE || (n_bins > 1 && $urandom_range(0, 7) == 0)) begin
        part_len = (phase == BIG_PHASE) ? BIG_PARTIAL : $urandom_range(1, n_bins - 1);
        repeat (part_len) begin
          feed_level(pick_level(), 1'b0, '0);
          rest_input(pick_gap());
        end
        partial_open = 1'b1;
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (display_due.size() > 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && display_due.size() == 0) begin
      $display("** spectrum_smooth_ballistics_top: PASSED **");
    end else begin
      $display("** spectrum_smooth_ballistics_top: FAILED **");
    end
    $finish;
  end

endmodule
